// ===== hw/rtl/kfi_pkg.sv =====
// Package: shared types, constants and codes of the keyframe interpolator.
`default_nettype none
package kfi_pkg;
  localparam int unsigned MaxKeysDef  = 64;
  localparam int unsigned FracBitsDef = 16;

  typedef enum logic [1:0] {
    MODE_ADD      = 2'd0,
    MODE_PLAY     = 2'd1,
    MODE_PLAY_ALL = 2'd2,
    MODE_UPDATE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_LOAD, S_PS_RD, S_PS_CHK, S_PE_RD, S_PE_CHK,
    S_UP_RD, S_UP_CHK, S_UP_FIN, S_DIV, S_MUL, S_DONE
  } fsm_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic signed [31:0] start_time;
    logic signed [31:0] end_time;
    logic signed [31:0] delta_time;
  } kfi_in_t;

  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic               running;
    logic [5:0]         frame_index;
    logic [1:0]         status;
  } kfi_out_t;

  // Saturate a 66-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh07FFFFFFF;
    lo = -66'sh080000000;
    if (v > hi) return 32'sh7FFFFFFF;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/keyframe_interpolator_unit.sv =====
// Top level: keyframe store with range search and linear interpolation.
//
//  channel | ports                  | handshake
//  --------+------------------------+-------------------------------
//  command | start_i, busy_o, cmd_i | taken when start_i && !busy_o
//  result  | done_o, res_o          | one word per command, 1 cycle
//
// Add passes through S_ADD, which writes the entry, to S_DONE; a full-store,
// empty-play or stopped-update word goes from S_IDLE straight to S_DONE.
// Play walks the stamp memory one entry per cycle, play_all after it has read
// its first and last stamps. Update steps frames one per cycle, then, short
// of the end frame, runs a 64-step bit-serial divider and three multiplies.
// Reset clears control and output registers; keyframe memory is read only below
// the fill count. The receiver cannot stall: done_o pulses for one cycle.
`default_nettype none
module keyframe_interpolator_unit #(
  parameter int unsigned MaxKeys  = kfi_pkg::MaxKeysDef,
  parameter int unsigned FracBits = kfi_pkg::FracBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire kfi_pkg::kfi_in_t cmd_i,
  output logic                  busy_o,
  output logic                  done_o,
  output kfi_pkg::kfi_out_t     res_o
);
  import kfi_pkg::*;

  localparam int unsigned AW = $clog2(MaxKeys);
  localparam int unsigned CW = $clog2(MaxKeys + 1);
  localparam logic [31:0] DenTenth = 32'(((64'd1 << FracBits) + 64'd5) / 64'd10);
  localparam logic signed [33:0] TLim = 34'sd536870912;

  // Memory: one word of four fields per entry.
  logic [127:0] mem_q [MaxKeys];
  logic [127:0] rd_q;
  logic [AW-1:0] raddr;
  logic          we;

  fsm_e state_q, state_d;
  kfi_in_t cmd_q;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] cur_q, cur_d, fin_q, fin_d, idx_q, idx_d;
  logic          run_q, run_d;
  logic signed [31:0] clk_q, clk_d, st_q, st_d, et_q, et_d;
  logic signed [31:0] vec_q [3];
  logic signed [31:0] vec_d [3];
  logic [1:0]  stat_q, stat_d;
  logic signed [31:0] prev_q, prev_d;   // stamp[idx-1] going up, stamp[idx] down
  logic [127:0] a_q, a_d;               // entry at current frame
  logic [1:0]  comp_q, comp_d;
  logic signed [33:0] t_q, t_d;
  logic        div_go;
  logic [63:0] div_num;
  logic        div_neg;
  logic [31:0] div_den;
  logic        div_done;
  logic [63:0] div_quo;
  logic        div_qneg;
  logic signed [31:0] rd_t;
  logic signed [33:0] csum;

  kfi_divider u_div (
    .clk_i, .rst_ni, .start_i(div_go), .num_i(div_num), .num_neg_i(div_neg),
    .den_i(div_den), .done_o(div_done), .quo_o(div_quo), .neg_o(div_qneg)
  );

  assign rd_t = rd_q[127:96];

  always_ff @(posedge clk_i) begin
    if (we) mem_q[count_q[AW-1:0]] <= {cmd_q.key_time, cmd_q.key_x, cmd_q.key_y, cmd_q.key_z};
    rd_q <= mem_q[raddr];
  end

  // Next state and data path.
  always_comb begin
    logic signed [63:0] num;
    logic signed [32:0] den;
    logic [63:0] mag;
    logic signed [63:0] q;
    logic signed [32:0] diff;
    logic signed [65:0] prod;
    logic signed [65:0] fl;
    logic signed [31:0] av;
    logic signed [31:0] bv;
    state_d = state_q; count_d = count_q; cur_d = cur_q; fin_d = fin_q;
    idx_d = idx_q; run_d = run_q; clk_d = clk_q; st_d = st_q; et_d = et_q;
    vec_d = vec_q; stat_d = stat_q; prev_d = prev_q; a_d = a_q;
    comp_d = comp_q; t_d = t_q; raddr = idx_q; we = 1'b0;
    div_go = 1'b0; div_num = '0; div_neg = 1'b0; div_den = '0;
    num = '0; den = '0; mag = '0; q = '0; diff = '0; prod = '0; fl = '0;
    av = '0; bv = '0; csum = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          stat_d = ST_OK;
          unique case (mode_e'(cmd_i.mode))
            MODE_ADD: begin
              if (count_q == CW'(MaxKeys)) begin
                stat_d = ST_FULL;
                state_d = S_DONE;
              end else state_d = S_ADD;
            end
            MODE_PLAY, MODE_PLAY_ALL: begin
              if (count_q == '0) begin
                stat_d = ST_EMPTY;
                state_d = S_DONE;
              end else begin
                st_d = cmd_i.start_time;
                et_d = cmd_i.end_time;
                idx_d = '0;
                state_d = S_LOAD;
              end
            end
            MODE_UPDATE: begin
              if (!run_q) state_d = S_DONE;
              else begin
                csum = 34'(clk_q) + 34'(cmd_i.delta_time);
                clk_d = sat32(66'(csum));
                idx_d = cur_q;
                state_d = S_UP_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_ADD: begin
        // Write the entry and take the first one as the current vector.
        we = 1'b1;
        if (count_q == '0) begin
          vec_d[0] = cmd_q.key_x; vec_d[1] = cmd_q.key_y; vec_d[2] = cmd_q.key_z;
        end
        count_d = count_q + CW'(1);
        state_d = S_DONE;
      end
      S_LOAD: begin
        // Fetch the first and last stamps for play_all.
        raddr = '0;
        state_d = S_PS_RD;
        if (mode_e'(cmd_q.mode) == MODE_PLAY_ALL) begin
          idx_d = AW'(count_q - CW'(1));
          state_d = S_PE_RD;
          comp_d = 2'd3;
        end
      end
      S_PE_RD: begin
        if (comp_q == 2'd3) begin
          st_d = rd_t;          // stamp 0
          raddr = idx_q;
          comp_d = 2'd2;
        end else if (comp_q == 2'd2) begin
          et_d = rd_t;          // last stamp
          comp_d = 2'd0;
          idx_d = '0;
          raddr = '0;
          state_d = S_PS_RD;
        end
      end
      S_PS_RD: begin
        raddr = idx_q;
        cur_d = '0; fin_d = '0; run_d = 1'b1; clk_d = st_q;
        if (count_q <= CW'(1)) state_d = S_DONE;
        else begin
          prev_d = rd_t;
          idx_d = idx_q + AW'(1);
          raddr = idx_q + AW'(1);
          state_d = S_PS_CHK;
        end
      end
      S_PS_CHK: begin
        // Hold the search at the first bracketing pair or the last entry.
        if ((prev_q <= st_q && st_q < rd_t) || CW'(idx_q) == count_q - CW'(1)) begin
          cur_d = (prev_q <= st_q && st_q < rd_t) ? idx_q - AW'(1) : idx_q;
          idx_d = AW'(count_q - CW'(1));
          raddr = AW'(count_q - CW'(1));
          state_d = S_PE_CHK;
          comp_d = 2'd1;
        end else begin
          prev_d = rd_t;
          idx_d = idx_q + AW'(1);
          raddr = idx_q + AW'(1);
        end
      end
      S_PE_CHK: begin
        // comp 1: rd is stamp[idx]; comp 0: rd is stamp[idx-1].
        if (idx_q == '0) begin
          fin_d = '0;
          state_d = S_DONE;
        end else if (comp_q == 2'd1) begin
          prev_d = rd_t;
          raddr = idx_q - AW'(1);
          comp_d = 2'd0;
        end else begin
          if (rd_t < et_q && et_q <= prev_q) begin
            fin_d = idx_q;
            state_d = S_DONE;
          end else begin
            prev_d = rd_t;
            idx_d = idx_q - AW'(1);
            raddr = idx_q - AW'(2);
          end
        end
      end
      S_UP_RD: begin
        // Past the end frame, fetch the end frame itself.
        raddr = (cur_q >= fin_q) ? fin_q : cur_q;
        state_d = S_UP_CHK;
        comp_d = 2'd1;
      end
      S_UP_CHK: begin
        // comp 1: rd is entry cur; comp 0: rd is entry cur+1.
        if (comp_q == 2'd1) begin
          a_d = rd_q;
          raddr = cur_q + AW'(1);
          comp_d = 2'd0;
          if (cur_q >= fin_q) state_d = S_UP_FIN;
        end else if (rd_t < clk_q && cur_q < fin_q) begin
          cur_d = cur_q + AW'(1);
          a_d = rd_q;
          raddr = cur_q + AW'(2);
          if (cur_q + AW'(1) >= fin_q) state_d = S_UP_FIN;
        end else begin
          num = 64'(clk_q) - 64'(signed'(a_q[127:96]));
          den = 33'(rd_t) - 33'(signed'(a_q[127:96]));
          if (den <= 0) den = 33'(DenTenth);
          num = num <<< FracBits;
          div_go = 1'b1;
          div_neg = num[63];
          div_num = num[63] ? 64'(-num) : 64'(num);
          div_den = den[31:0] == '0 ? 32'hFFFFFFFF : den[31:0];
          if (den[32] == 1'b0 && den > 33'sh0FFFFFFFF) div_den = 32'hFFFFFFFF;
          a_d[95:0] = a_q[95:0];
          prev_d = '0;
          state_d = S_DIV;
          raddr = cur_q + AW'(1);
        end
      end
      S_UP_FIN: begin
        cur_d = fin_q;
        run_d = 1'b0;
        if (cur_q >= fin_q && comp_q == 2'd0) begin
          vec_d[0] = a_q[95:64]; vec_d[1] = a_q[63:32]; vec_d[2] = a_q[31:0];
        end
        state_d = S_DONE;
      end
      S_DIV: begin
        raddr = cur_q + AW'(1);
        if (div_done) begin
          mag = div_quo;
          q = div_qneg ? -$signed(mag) : $signed(mag);
          if (q > 64'(TLim)) t_d = TLim;
          else if (q < -64'(TLim)) t_d = -TLim;
          else t_d = 34'(q);
          comp_d = 2'd0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // One component per cycle: a + floor((b - a) * t >> FracBits).
        raddr = cur_q + AW'(1);
        unique case (comp_q)
          2'd0: begin av = a_q[95:64]; bv = rd_q[95:64]; end
          2'd1: begin av = a_q[63:32]; bv = rd_q[63:32]; end
          default: begin av = a_q[31:0]; bv = rd_q[31:0]; end
        endcase
        diff = 33'(bv) - 33'(av);
        prod = 66'(diff) * 66'(t_q);
        fl = prod >>> FracBits;
        vec_d[comp_q] = sat32(66'(av) + fl);
        if (comp_q == 2'd2) state_d = S_DONE;
        else comp_d = comp_q + 2'd1;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; cur_q <= '0; fin_q <= '0; run_q <= 1'b0;
      clk_q <= '0; stat_q <= ST_OK; comp_q <= '0; idx_q <= '0;
      vec_q[0] <= '0; vec_q[1] <= '0; vec_q[2] <= '0;
    end else begin
      state_q <= state_d; count_q <= count_d; cur_q <= cur_d; fin_q <= fin_d;
      run_q <= run_d; clk_q <= clk_d; stat_q <= stat_d; comp_q <= comp_d;
      idx_q <= idx_d; vec_q <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == S_IDLE) cmd_q <= cmd_i;
    st_q <= st_d; et_q <= et_d; prev_q <= prev_d; a_q <= a_d; t_q <= t_d;
  end

  // Outputs.
  always_comb begin
    busy_o = (state_q != S_IDLE);
    done_o = (state_q == S_DONE);
    res_o.cur_x = vec_q[0];
    res_o.cur_y = vec_q[1];
    res_o.cur_z = vec_q[2];
    res_o.running = run_q;
    res_o.frame_index = 6'(cur_q);
    res_o.status = stat_q;
  end

`ifndef SYNTH
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxKeys)) else $error("fill count overflow");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("command not taken");
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_FIN) |=> !run_q) else $error("stop missed");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/kfi_divider.sv =====
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module kfi_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic        num_neg_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o,
  output logic             neg_o
);
  import kfi_pkg::*;

  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic [32:0] shifted;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    shifted = {rem_q[31:0], quo_q[63]};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; cnt_d = 7'd0;
      busy_d = 1'b1; neg_d = num_neg_i;
    end else if (busy_q) begin
      // Advance one restoring step.
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign neg_o  = neg_q;
endmodule
`default_nettype wire
